// File: src/gat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gat_pkg
// Shared types and constants for the graph adjacency table.
// ----------------------------------------------------------------------------
package gat_pkg;

    localparam int MAX_VERTICES_DEF = 8;
    localparam int MAX_EDGES_DEF    = 8;
    localparam int LABEL_W          = 32;

    typedef enum logic [1:0] {
        OP_INS_V = 2'd0,
        OP_INS_E = 2'd1,
        OP_REM_E = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_VADDED   = 4'd0,
        ST_TFULL    = 4'd1,
        ST_VEXISTS  = 4'd2,
        ST_EADDED   = 4'd3,
        ST_NOORIGIN = 4'd4,
        ST_EEXISTS  = 4'd5,
        ST_EREMOVED = 4'd6,
        ST_EMISSING = 4'd7,
        ST_LFULL    = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_VSRCH,
        S_CNT,
        S_ESRCH,
        S_SHIFT
    } state_t;

    // Write strobes from the sequencer to the storage.
    typedef struct packed {
        logic lbl;
        logic cnt;
        logic edg;
    } mem_we_t;

endpackage

// File: src/graph_adjacency_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_adjacency_table
// Bounded directed graph: a vertex label table with an ordered destination
// list per vertex, updated by one operation per input beat.
// ----------------------------------------------------------------------------
// Each input beat inserts a vertex, appends an edge or removes an edge and
// yields one status beat; operation code 3 is consumed without a status.
// Labels and destinations live in memories with a single registered read
// port, and one 32-bit comparator walks them one entry per cycle. A vertex
// insert searches the labels (up to MAX_VERTICES probed); an edge operation
// searches the labels, reads the list length, searches the list (up to
// MAX_EDGES entries probed) and on removal moves the later entries down to
// close the gap. A full or an empty table answers without a search, and an
// edge operation on an empty list without a list search. The next input
// beat can be taken in the same cycle that the status is offered. One
// operation is in work at a time; the status sits in an output register, so
// the next beat is taken while it waits, and that operation finishes once
// the register frees. No clearing pass is needed after reset.
module graph_adjacency_table #(
    parameter int MAX_VERTICES = gat_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = gat_pkg::MAX_EDGES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         op,
    input  logic signed [gat_pkg::LABEL_W-1:0] label_a,
    input  logic signed [gat_pkg::LABEL_W-1:0] label_b,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [3:0]                         status
);

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);

    gat_pkg::mem_we_t            we;
    logic [VW-1:0]               lbl_waddr;
    logic [gat_pkg::LABEL_W-1:0] lbl_wdata;
    logic [VW-1:0]               lbl_raddr;
    logic [gat_pkg::LABEL_W-1:0] lbl_rdata;
    logic [VW-1:0]               cnt_waddr;
    logic [CW-1:0]               cnt_wdata;
    logic [VW-1:0]               cnt_raddr;
    logic [CW-1:0]               cnt_rdata;
    logic [VW-1:0]               edge_v;
    logic [EW-1:0]               edge_wj;
    logic [gat_pkg::LABEL_W-1:0] edge_wdata;
    logic [EW-1:0]               edge_rj;
    logic [gat_pkg::LABEL_W-1:0] edge_rdata;

    gat_ctrl #(
        .MAX_V (MAX_VERTICES),
        .MAX_E (MAX_EDGES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .label_a    (label_a),
        .label_b    (label_b),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .we         (we),
        .lbl_waddr  (lbl_waddr),
        .lbl_wdata  (lbl_wdata),
        .lbl_raddr  (lbl_raddr),
        .lbl_rdata  (lbl_rdata),
        .cnt_waddr  (cnt_waddr),
        .cnt_wdata  (cnt_wdata),
        .cnt_raddr  (cnt_raddr),
        .cnt_rdata  (cnt_rdata),
        .edge_v     (edge_v),
        .edge_wj    (edge_wj),
        .edge_wdata (edge_wdata),
        .edge_rj    (edge_rj),
        .edge_rdata (edge_rdata)
    );

    gat_store #(
        .MAX_V (MAX_VERTICES),
        .MAX_E (MAX_EDGES)
    ) u_store (
        .clk        (clk),
        .we         (we),
        .lbl_waddr  (lbl_waddr),
        .lbl_wdata  (lbl_wdata),
        .lbl_raddr  (lbl_raddr),
        .lbl_rdata  (lbl_rdata),
        .cnt_waddr  (cnt_waddr),
        .cnt_wdata  (cnt_wdata),
        .cnt_raddr  (cnt_raddr),
        .cnt_rdata  (cnt_rdata),
        .edge_v     (edge_v),
        .edge_wj    (edge_wj),
        .edge_wdata (edge_wdata),
        .edge_rj    (edge_rj),
        .edge_rdata (edge_rdata)
    );

endmodule

// File: src/gat_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gat_store
// Label table, per-vertex list lengths and destination lists, each a memory
// with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gat_store #(
    parameter int MAX_V = gat_pkg::MAX_VERTICES_DEF,
    parameter int MAX_E = gat_pkg::MAX_EDGES_DEF,
    localparam int VW = (MAX_V > 1) ? $clog2(MAX_V) : 1,
    localparam int EW = (MAX_E > 1) ? $clog2(MAX_E) : 1,
    localparam int CW = $clog2(MAX_E + 1)
) (
    input  logic                          clk,
    input  gat_pkg::mem_we_t              we,
    input  logic [VW-1:0]                 lbl_waddr,
    input  logic [gat_pkg::LABEL_W-1:0]   lbl_wdata,
    input  logic [VW-1:0]                 lbl_raddr,
    output logic [gat_pkg::LABEL_W-1:0]   lbl_rdata,
    input  logic [VW-1:0]                 cnt_waddr,
    input  logic [CW-1:0]                 cnt_wdata,
    input  logic [VW-1:0]                 cnt_raddr,
    output logic [CW-1:0]                 cnt_rdata,
    input  logic [VW-1:0]                 edge_v,
    input  logic [EW-1:0]                 edge_wj,
    input  logic [gat_pkg::LABEL_W-1:0]   edge_wdata,
    input  logic [EW-1:0]                 edge_rj,
    output logic [gat_pkg::LABEL_W-1:0]   edge_rdata
);

    logic [gat_pkg::LABEL_W-1:0] lbl_mem  [MAX_V];
    logic [CW-1:0]               cnt_mem  [MAX_V];
    logic [gat_pkg::LABEL_W-1:0] edge_mem [MAX_V][MAX_E];

    always_ff @(posedge clk)
    begin
        if (we.lbl)
        begin
            lbl_mem[lbl_waddr] <= lbl_wdata;
        end
        lbl_rdata <= lbl_mem[lbl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we.cnt)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we.edg)
        begin
            edge_mem[edge_v][edge_wj] <= edge_wdata;
        end
        edge_rdata <= edge_mem[edge_v][edge_rj];
    end

endmodule

// File: src/gat_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gat_ctrl
// Sequencer: steps one 32-bit comparator over the label table and then over
// one destination list, closes gaps on removal and holds the result beat.
// ----------------------------------------------------------------------------
module gat_ctrl #(
    parameter int MAX_V = gat_pkg::MAX_VERTICES_DEF,
    parameter int MAX_E = gat_pkg::MAX_EDGES_DEF,
    localparam int VW = (MAX_V > 1) ? $clog2(MAX_V) : 1,
    localparam int EW = (MAX_E > 1) ? $clog2(MAX_E) : 1,
    localparam int CW = $clog2(MAX_E + 1),
    localparam int NW = $clog2(MAX_V + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    op,
    input  logic [gat_pkg::LABEL_W-1:0]   label_a,
    input  logic [gat_pkg::LABEL_W-1:0]   label_b,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [3:0]                    status,
    output gat_pkg::mem_we_t              we,
    output logic [VW-1:0]                 lbl_waddr,
    output logic [gat_pkg::LABEL_W-1:0]   lbl_wdata,
    output logic [VW-1:0]                 lbl_raddr,
    input  logic [gat_pkg::LABEL_W-1:0]   lbl_rdata,
    output logic [VW-1:0]                 cnt_waddr,
    output logic [CW-1:0]                 cnt_wdata,
    output logic [VW-1:0]                 cnt_raddr,
    input  logic [CW-1:0]                 cnt_rdata,
    output logic [VW-1:0]                 edge_v,
    output logic [EW-1:0]                 edge_wj,
    output logic [gat_pkg::LABEL_W-1:0]   edge_wdata,
    output logic [EW-1:0]                 edge_rj,
    input  logic [gat_pkg::LABEL_W-1:0]   edge_rdata
);

    gat_pkg::state_t             state_reg, state_next;
    logic [1:0]                  op_reg, op_next;
    logic [gat_pkg::LABEL_W-1:0] a_reg, a_next;
    logic [gat_pkg::LABEL_W-1:0] b_reg, b_next;
    logic [NW-1:0]               vcount_reg, vcount_next;
    logic [VW-1:0]               vi_reg, vi_next;
    logic [VW-1:0]               v_reg, v_next;
    logic [CW-1:0]               ecnt_reg, ecnt_next;
    logic [EW-1:0]               ej_reg, ej_next;
    logic                        out_valid_reg, out_valid_next;
    gat_pkg::status_t            status_reg, status_next;

    logic                        fin;
    logic                        out_free;
    gat_pkg::status_t            res;
    logic [NW-1:0]               vi_inc;
    logic [CW-1:0]               ej_inc;
    logic [CW-1:0]               ej_inc2;
    logic [EW-1:0]               hold_rj;
    logic [gat_pkg::LABEL_W-1:0] cmp_lhs;
    logic [gat_pkg::LABEL_W-1:0] cmp_rhs;
    logic                        cmp_hit;

    assign in_ready  = (state_reg == gat_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign vi_inc   = NW'(vi_reg) + NW'(1);
    assign ej_inc   = CW'(ej_reg) + CW'(1);
    assign ej_inc2  = CW'(ej_reg) + CW'(2);
    // The comparator looks at the label table during the vertex search and at
    // the destination list otherwise.
    assign cmp_lhs  = (state_reg == gat_pkg::S_VSRCH) ? lbl_rdata : edge_rdata;
    assign cmp_rhs  = (state_reg == gat_pkg::S_VSRCH) ? a_reg : b_reg;
    assign cmp_hit  = (cmp_lhs == cmp_rhs);
    // In the shift loop the read port already points one entry ahead.
    assign hold_rj  = (state_reg == gat_pkg::S_SHIFT) ? EW'(ej_inc) : ej_reg;

    assign edge_v = v_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        vcount_next    = vcount_reg;
        vi_next        = vi_reg;
        v_next         = v_reg;
        ecnt_next      = ecnt_reg;
        ej_next        = ej_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        fin            = 1'b0;
        res            = gat_pkg::ST_VADDED;
        we             = '0;
        lbl_waddr      = VW'(vcount_reg);
        lbl_wdata      = a_reg;
        lbl_raddr      = vi_reg;
        cnt_waddr      = v_reg;
        cnt_wdata      = '0;
        cnt_raddr      = v_reg;
        edge_wj        = ej_reg;
        edge_wdata     = b_reg;
        edge_rj        = hold_rj;

        case (state_reg)
            gat_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    a_next     = label_a;
                    b_next     = label_b;
                    state_next = gat_pkg::S_START;
                end
            end

            gat_pkg::S_START:
            begin
                vi_next   = '0;
                lbl_raddr = '0;
                case (op_reg)
                    gat_pkg::OP_INS_V:
                    begin
                        if (vcount_reg >= NW'(MAX_V))
                        begin
                            fin = 1'b1;
                            res = gat_pkg::ST_TFULL;
                        end
                        else if (vcount_reg == '0)
                        begin
                            fin         = 1'b1;
                            res         = gat_pkg::ST_VADDED;
                            we.lbl      = 1'b1;
                            we.cnt      = 1'b1;
                            cnt_waddr   = VW'(vcount_reg);
                            vcount_next = vcount_reg + NW'(1);
                        end
                        else
                        begin
                            state_next = gat_pkg::S_VSRCH;
                        end
                    end
                    gat_pkg::OP_INS_E, gat_pkg::OP_REM_E:
                    begin
                        if (vcount_reg == '0)
                        begin
                            fin = 1'b1;
                            res = gat_pkg::ST_NOORIGIN;
                        end
                        else
                        begin
                            state_next = gat_pkg::S_VSRCH;
                        end
                    end
                    default:
                    begin
                        // Undefined operation: no result beat, no change.
                        state_next = gat_pkg::S_IDLE;
                    end
                endcase
            end

            gat_pkg::S_VSRCH:
            begin
                if (op_reg == gat_pkg::OP_INS_V)
                begin
                    if (cmp_hit)
                    begin
                        fin = 1'b1;
                        res = gat_pkg::ST_VEXISTS;
                    end
                    else if (vi_inc >= vcount_reg)
                    begin
                        fin         = 1'b1;
                        res         = gat_pkg::ST_VADDED;
                        we.lbl      = 1'b1;
                        we.cnt      = 1'b1;
                        cnt_waddr   = VW'(vcount_reg);
                        vcount_next = vcount_reg + NW'(1);
                    end
                    else
                    begin
                        vi_next   = VW'(vi_inc);
                        lbl_raddr = VW'(vi_inc);
                    end
                end
                else
                begin
                    if (cmp_hit)
                    begin
                        v_next     = vi_reg;
                        cnt_raddr  = vi_reg;
                        state_next = gat_pkg::S_CNT;
                    end
                    else if (vi_inc >= vcount_reg)
                    begin
                        fin = 1'b1;
                        res = gat_pkg::ST_NOORIGIN;
                    end
                    else
                    begin
                        vi_next   = VW'(vi_inc);
                        lbl_raddr = VW'(vi_inc);
                    end
                end
            end

            gat_pkg::S_CNT:
            begin
                ecnt_next = cnt_rdata;
                if (cnt_rdata == '0)
                begin
                    fin = 1'b1;
                    if (op_reg == gat_pkg::OP_INS_E)
                    begin
                        res       = gat_pkg::ST_EADDED;
                        we.edg    = 1'b1;
                        edge_wj   = '0;
                        we.cnt    = 1'b1;
                        cnt_wdata = CW'(1);
                    end
                    else
                    begin
                        res = gat_pkg::ST_EMISSING;
                    end
                end
                else
                begin
                    ej_next    = '0;
                    edge_rj    = '0;
                    state_next = gat_pkg::S_ESRCH;
                end
            end

            gat_pkg::S_ESRCH:
            begin
                if (op_reg == gat_pkg::OP_INS_E)
                begin
                    if (cmp_hit)
                    begin
                        fin = 1'b1;
                        res = gat_pkg::ST_EEXISTS;
                    end
                    else if (ej_inc >= ecnt_reg)
                    begin
                        fin = 1'b1;
                        if (ecnt_reg >= CW'(MAX_E))
                        begin
                            res = gat_pkg::ST_LFULL;
                        end
                        else
                        begin
                            res       = gat_pkg::ST_EADDED;
                            we.edg    = 1'b1;
                            edge_wj   = EW'(ecnt_reg);
                            we.cnt    = 1'b1;
                            cnt_wdata = ecnt_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        ej_next = EW'(ej_inc);
                        edge_rj = EW'(ej_inc);
                    end
                end
                else
                begin
                    if (cmp_hit)
                    begin
                        if (ej_inc >= ecnt_reg)
                        begin
                            fin       = 1'b1;
                            res       = gat_pkg::ST_EREMOVED;
                            we.cnt    = 1'b1;
                            cnt_wdata = ecnt_reg - CW'(1);
                        end
                        else
                        begin
                            edge_rj    = EW'(ej_inc);
                            state_next = gat_pkg::S_SHIFT;
                        end
                    end
                    else if (ej_inc >= ecnt_reg)
                    begin
                        fin = 1'b1;
                        res = gat_pkg::ST_EMISSING;
                    end
                    else
                    begin
                        ej_next = EW'(ej_inc);
                        edge_rj = EW'(ej_inc);
                    end
                end
            end

            gat_pkg::S_SHIFT:
            begin
                // Read data is the entry after ej; move it down one place.
                we.edg     = 1'b1;
                edge_wj    = ej_reg;
                edge_wdata = edge_rdata;
                ej_next    = EW'(ej_inc);
                if (ej_inc2 < ecnt_reg)
                begin
                    edge_rj = EW'(ej_inc2);
                end
                else
                begin
                    fin       = 1'b1;
                    res       = gat_pkg::ST_EREMOVED;
                    we.cnt    = 1'b1;
                    cnt_wdata = ecnt_reg - CW'(1);
                end
            end

            default:
            begin
                state_next = gat_pkg::S_IDLE;
            end
        endcase

        if (fin)
        begin
            if (out_free)
            begin
                state_next     = gat_pkg::S_IDLE;
                out_valid_next = 1'b1;
                status_next    = res;
            end
            else
            begin
                // Result register still occupied: freeze and reread the same entries.
                state_next  = state_reg;
                vcount_next = vcount_reg;
                vi_next     = vi_reg;
                v_next      = v_reg;
                ecnt_next   = ecnt_reg;
                ej_next     = ej_reg;
                we          = '0;
                lbl_raddr   = vi_reg;
                cnt_raddr   = v_reg;
                edge_rj     = hold_rj;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gat_pkg::S_IDLE;
            vcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        vi_reg     <= vi_next;
        v_reg      <= v_next;
        ecnt_reg   <= ecnt_next;
        ej_reg     <= ej_next;
        status_reg <= status_next;
    end

    a_vcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg <= NW'(MAX_V))
        else $error("vertex count beyond table size");

    a_vadd_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        we.lbl |-> (we.cnt && (cnt_wdata == '0) && (vcount_reg < NW'(MAX_V))))
        else $error("vertex insert without clearing its list length");

    a_shift_only_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gat_pkg::S_SHIFT) |-> (op_reg == gat_pkg::OP_REM_E))
        else $error("shift loop entered by an operation other than remove");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) != gat_pkg::S_IDLE))
        else $error("result beat without an operation in progress");

    a_list_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        we.cnt |-> (cnt_wdata <= CW'(MAX_E)))
        else $error("list length written beyond capacity");

endmodule

// File: tb/graph_adjacency_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_adjacency_table_tb
// Self-checking testbench for the bounded adjacency table.
// ----------------------------------------------------------------------------
// Each accepted input beat is applied to a shadow copy of the graph held in
// the testbench, and the status it should produce is queued. A monitor pops
// the queue on every status beat and compares. Directed tests cover empty
// and full tables, full and shrinking lists and the undefined operation;
// the random part then works mostly on existing vertices and a small pool
// of destinations so that duplicates, full lists and removals keep occurring.
// ----------------------------------------------------------------------------
module graph_adjacency_table_tb;

    localparam int NV = gat_pkg::MAX_VERTICES_DEF;
    localparam int NE = gat_pkg::MAX_EDGES_DEF;
    localparam logic [1:0] OP_UNDEF = 2'd3;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_GAP = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  op = gat_pkg::OP_INS_V;
    logic [31:0] label_a = '0;
    logic [31:0] label_b = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  status;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;

    gat_pkg::status_t pending_status[$];

    // Shadow copy of the graph.
    logic [31:0] vert_labels[NV];
    int          vert_count = 0;
    logic [31:0] dest_lists[NV][NE];
    int          dest_count[NV];

    logic [31:0] dest_pool[12];

    graph_adjacency_table #(
        .MAX_VERTICES(NV),
        .MAX_EDGES   (NE)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .label_a  (label_a),
        .label_b  (label_b),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status   (status)
    );

    always #10 clk = ~clk;

    function automatic int find_vertex(input logic [31:0] lbl);
        for (int i = 0; i < vert_count; i++)
        begin
            if (vert_labels[i] == lbl)
                return i;
        end
        return vert_count;
    endfunction

    function automatic int find_dest(input int v, input logic [31:0] dst);
        for (int j = 0; j < dest_count[v]; j++)
        begin
            if (dest_lists[v][j] == dst)
                return j;
        end
        return dest_count[v];
    endfunction

    // Applies one operation to the shadow graph; returns 0 when no status
    // beat is produced.
    function automatic bit graph_apply(input logic [1:0] opc, input logic [31:0] a,
                                       input logic [31:0] b,
                                       output gat_pkg::status_t st);
        int v;
        int j;
        st = gat_pkg::ST_VADDED;
        if (opc == OP_UNDEF)
            return 1'b0;
        v = find_vertex(a);
        if (opc == gat_pkg::OP_INS_V)
        begin
            // The capacity check comes before the duplicate check.
            if (vert_count >= NV)
                st = gat_pkg::ST_TFULL;
            else if (v < vert_count)
                st = gat_pkg::ST_VEXISTS;
            else
            begin
                vert_labels[vert_count] = a;
                dest_count[vert_count] = 0;
                vert_count++;
                st = gat_pkg::ST_VADDED;
            end
        end
        else if (v >= vert_count)
            st = gat_pkg::ST_NOORIGIN;
        else if (opc == gat_pkg::OP_INS_E)
        begin
            j = find_dest(v, b);
            if (j < dest_count[v])
                st = gat_pkg::ST_EEXISTS;
            else if (dest_count[v] >= NE)
                st = gat_pkg::ST_LFULL;
            else
            begin
                dest_lists[v][dest_count[v]] = b;
                dest_count[v]++;
                st = gat_pkg::ST_EADDED;
            end
        end
        else
        begin
            j = find_dest(v, b);
            if (j >= dest_count[v])
                st = gat_pkg::ST_EMISSING;
            else
            begin
                for (int k = j; k + 1 < dest_count[v]; k++)
                    dest_lists[v][k] = dest_lists[v][k + 1];
                dest_count[v]--;
                st = gat_pkg::ST_EREMOVED;
            end
        end
        return 1'b1;
    endfunction

    task automatic send_beat(input logic [1:0] opc, input logic [31:0] a,
                             input logic [31:0] b);
        int gap;
        gat_pkg::status_t st;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op      <= opc;
        label_a <= a;
        label_b <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (graph_apply(opc, a, b, st))
            pending_status.push_back(st);
    endtask

    // Holds the input side off until every queued status has been seen.
    task automatic drain_status;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_status.size() != 0)
            @(posedge clk);
    endtask

    function automatic void report_mismatch(input string what, input logic [3:0] exp_st,
                                            input logic [3:0] got_st);
        if (mismatch_count < 10)
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, exp_st, got_st);
        mismatch_count++;
    endfunction

    // Status monitor and receiver back-pressure.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_status.size() == 0)
                report_mismatch("unexpected status beat", 4'hf, status);
            else if (status !== pending_status[0])
            begin
                report_mismatch("status", pending_status[0], status);
                void'(pending_status.pop_front());
            end
            else
                void'(pending_status.pop_front());
        end
    end

    function automatic logic [31:0] pick_dest;
        if ($urandom_range(99) < 80)
            return dest_pool[$urandom_range(11)];
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_origin;
        int r;
        r = $urandom_range(99);
        if (vert_count > 0 && r < 75)
            return vert_labels[$urandom_range(vert_count - 1)];
        if (r < 88)
            return dest_pool[$urandom_range(11)];
        return $urandom;
    endfunction

    task automatic test_origin_missing;
        send_beat(gat_pkg::OP_REM_E, 32'h0000_0000, 32'h0000_0000);
        send_beat(gat_pkg::OP_INS_E, 32'h7fff_ffff, 32'h8000_0000);
    endtask

    task automatic test_vertex_insert;
        send_beat(gat_pkg::OP_INS_V, 32'h8000_0000, 32'hffff_ffff);
        send_beat(gat_pkg::OP_INS_V, 32'h7fff_ffff, 32'h0000_0000);
        send_beat(gat_pkg::OP_INS_V, 32'h0000_0000, 32'h7fff_ffff);
        send_beat(gat_pkg::OP_INS_V, 32'h8000_0000, 32'h0000_0000);
    endtask

    task automatic test_undefined_op;
        send_beat(OP_UNDEF, 32'hffff_ffff, 32'hffff_ffff);
        send_beat(OP_UNDEF, 32'h0000_0000, 32'h8000_0000);
    endtask

    task automatic test_edge_lists;
        logic [31:0] dests[NE];
        dests = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                  32'd1, 32'd2, 32'd3, 32'd4};
        foreach (dests[i])
            send_beat(gat_pkg::OP_INS_E, 32'h8000_0000, dests[i]);
        // A duplicate on a full list reports the duplicate, not the overflow.
        send_beat(gat_pkg::OP_INS_E, 32'h8000_0000, 32'h7fff_ffff);
        send_beat(gat_pkg::OP_INS_E, 32'h8000_0000, 32'd5);
        send_beat(gat_pkg::OP_REM_E, 32'h8000_0000, 32'h0000_0000);
        send_beat(gat_pkg::OP_REM_E, 32'h8000_0000, 32'h0000_0000);
        send_beat(gat_pkg::OP_REM_E, 32'h8000_0000, 32'h8000_0000);
        send_beat(gat_pkg::OP_REM_E, 32'h8000_0000, 32'd4);
        send_beat(gat_pkg::OP_INS_E, 32'h8000_0000, 32'd5);
        send_beat(gat_pkg::OP_REM_E, 32'h7fff_ffff, 32'd5);
    endtask

    task automatic run_random_phase(input int beats);
        int sent;
        int r;
        sent = 0;
        while (sent < beats)
        begin
            r = $urandom_range(99);
            if (r < 10)
                send_beat(gat_pkg::OP_INS_V,
                          ($urandom_range(1) != 0) ? pick_dest() : $urandom, $urandom);
            else if (r < 55)
                send_beat(gat_pkg::OP_INS_E, pick_origin(), pick_dest());
            else if (r < 93)
                send_beat(gat_pkg::OP_REM_E, pick_origin(), pick_dest());
            else
                send_beat(OP_UNDEF, $urandom, $urandom);
            if (r < 93)
                sent++;
            if ($urandom_range(99) == 0)
                drain_status();
        end
    endtask

    task automatic test_random;
        dest_pool[0] = 32'h8000_0000;
        dest_pool[1] = 32'h7fff_ffff;
        dest_pool[2] = 32'h0000_0000;
        dest_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 12; i++)
            dest_pool[i] = $urandom;
        drain_status();
        run_random_phase(195);
        send_idle_pct = 67;
        recv_idle_pct = 7;
        drain_status();
        run_random_phase(195);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        drain_status();
        run_random_phase(195);
    endtask

    task automatic test_table_full;
        while (vert_count < NV)
            send_beat(gat_pkg::OP_INS_V, $urandom, $urandom);
        // On a full table even an existing label reports the table full.
        send_beat(gat_pkg::OP_INS_V, 32'h8000_0000, 32'h0000_0000);
        send_beat(gat_pkg::OP_INS_V, $urandom, 32'hffff_ffff);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 7;
        recv_idle_pct = 67;
        test_origin_missing();
        test_vertex_insert();
        test_undefined_op();
        test_edge_lists();
        test_random();
        test_table_full();
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
src/gat_pkg.sv
src/gat_store.sv
src/gat_ctrl.sv
src/graph_adjacency_table.sv
tb/graph_adjacency_table_tb.sv
